/* design/buq_pkg.sv */
`default_nettype none

package buq_pkg;

   // Ring geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef logic [PTR_W-1:0] ptr_type;

   // Event codes
   typedef enum logic [1:0] {
      FUNC_RECV   = 2'd0,
      FUNC_TXDONE = 2'd1,
      FUNC_WRITE  = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   // Input transaction
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       accepted;
   } rsp_type;

   // Queue memory write port
   typedef struct packed {
      logic       en;
      ptr_type    addr;
      logic [7:0] data;
   } mem_wr_type;

   // Queue memory read port
   typedef struct packed {
      logic    en;
      ptr_type addr;
   } mem_rd_type;

   // Decisions carried to the result stage
   typedef struct packed {
      logic       send_valid;
      logic       send_from_mem;
      logic       read_valid;
      logic       accepted;
      logic [7:0] data_byte;
   } pend_type;

   // Advance a ring index with wrap at the queue depth
   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/buq_ram.sv */
`default_nettype none

module buq_ram (
   input  wire logic               clock,
   input  wire buq_pkg::mem_wr_type wr,
   input  wire buq_pkg::mem_rd_type rd,
   output logic [7:0]              rd_data
);
   import buq_pkg::*;

   logic [7:0] mem [QUEUE_DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port; hold data between reads
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/buq_ctrl.sv */
`default_nettype none

module buq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire buq_pkg::req_type    req,
   output buq_pkg::mem_wr_type      rx_wr,
   output buq_pkg::mem_rd_type      rx_rd,
   output buq_pkg::mem_wr_type      tx_wr,
   output buq_pkg::mem_rd_type      tx_rd,
   output buq_pkg::pend_type        pend
);
   import buq_pkg::*;

   ptr_type rx_head_ff, rx_head_in;
   ptr_type rx_tail_ff, rx_tail_in;
   ptr_type tx_head_ff, tx_head_in;
   ptr_type tx_tail_ff, tx_tail_in;
   logic    busy_ff, busy_in;

   logic rx_full, rx_empty, tx_full, tx_empty;

   assign rx_full  = (ptr_next(rx_head_ff) == rx_tail_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign tx_full  = (ptr_next(tx_head_ff) == tx_tail_ff);
   assign tx_empty = (tx_head_ff == tx_tail_ff);

   // Decode the event, drive memory ports and next pointers
   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      busy_in    = busy_ff;

      rx_wr = '{en: 1'b0, addr: rx_head_ff, data: req.data_byte};
      tx_wr = '{en: 1'b0, addr: tx_head_ff, data: req.data_byte};
      rx_rd = '{en: 1'b0, addr: rx_tail_ff};
      tx_rd = '{en: 1'b0, addr: tx_tail_ff};

      pend.send_valid    = 1'b0;
      pend.send_from_mem = 1'b0;
      pend.read_valid    = 1'b0;
      pend.accepted      = 1'b1;
      pend.data_byte     = req.data_byte;

      case (req.func)
         FUNC_RECV: begin
            if (rx_full) begin
               pend.accepted = 1'b0;
            end else begin
               rx_wr.en   = accept;
               rx_head_in = ptr_next(rx_head_ff);
            end
         end
         FUNC_TXDONE: begin
            if (tx_empty) begin
               busy_in = 1'b0;
            end else begin
               tx_rd.en           = accept;
               tx_tail_in         = ptr_next(tx_tail_ff);
               pend.send_valid    = 1'b1;
               pend.send_from_mem = 1'b1;
            end
         end
         FUNC_WRITE: begin
            if (!busy_ff) begin
               busy_in         = 1'b1;
               pend.send_valid = 1'b1;
            end else if (tx_full) begin
               pend.accepted = 1'b0;
            end else begin
               tx_wr.en   = accept;
               tx_head_in = ptr_next(tx_head_ff);
            end
         end
         FUNC_READ: begin
            if (!rx_empty) begin
               rx_rd.en        = accept;
               rx_tail_in      = ptr_next(rx_tail_ff);
               pend.read_valid = 1'b1;
            end
         end
         default: begin
            pend.accepted = 1'b1;
         end
      endcase
   end

   // Commit pointer and busy updates on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         busy_ff    <= 1'b0;
      end else if (accept) begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

`default_nettype wire

/* design/buffered_uart_byte_queues.sv */
// Timing: a transaction is decoded and its memory read is done at the edge that accepts it,
//   into the pending register and the memory read register; the output register then loads
//   the result when the result side does not stall.
// Throughput: one transaction per cycle while the result side does not stall; the
//   single-ported read of each queue memory is used at most once per transaction.
// Reset: synchronous, clears all ring indices, the transmit-busy flag and valids;
//   queue memories are not cleared.
`default_nettype none

module buffered_uart_byte_queues (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire buq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output buq_pkg::rsp_type      rsp_data
);
   import buq_pkg::*;

   logic       accept;
   logic       load_rsp;
   mem_wr_type rx_wr, tx_wr;
   mem_rd_type rx_rd, tx_rd;
   logic [7:0] rx_rd_data, tx_rd_data;
   pend_type   pend_dec;

   pend_type   pend_ff;
   logic       pend_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff;

   // Handshake: hold input while a decoded transaction cannot move out
   assign load_rsp  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_valid_ff && !load_rsp;
   assign accept    = req_valid && !req_stall;

   buq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .rx_wr  (rx_wr),
      .rx_rd  (rx_rd),
      .tx_wr  (tx_wr),
      .tx_rd  (tx_rd),
      .pend   (pend_dec)
   );

   buq_ram u_rx_ram (
      .clock   (clock),
      .wr      (rx_wr),
      .rd      (rx_rd),
      .rd_data (rx_rd_data)
   );

   buq_ram u_tx_ram (
      .clock   (clock),
      .wr      (tx_wr),
      .rd      (tx_rd),
      .rd_data (tx_rd_data)
   );

   // Hold decoded transaction while memory read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         pend_valid_ff <= 1'b1;
      end else if (load_rsp) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_dec;
      end
   end

   // Assemble result fields from memory data
   always_comb begin
      rsp_in.send_valid = pend_ff.send_valid;
      rsp_in.send_byte  = !pend_ff.send_valid ? 8'd0 :
                          (pend_ff.send_from_mem ? tx_rd_data : pend_ff.data_byte);
      rsp_in.read_valid = pend_ff.read_valid;
      rsp_in.read_byte  = pend_ff.read_valid ? rx_rd_data : 8'd0;
      rsp_in.accepted   = pend_ff.accepted;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp && pend_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* verif/buq_checker.sv */
`timescale 1ns / 1ps

module buq_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire buq_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire buq_pkg::rsp_type rsp_data,
   output int                    error_count,
   output int                    results_due
);

   import buq_pkg::*;

   // Shadow copy of both rings and the transmitter flag
   logic [7:0] rx_bytes [QUEUE_DEPTH];
   logic [7:0] tx_bytes [QUEUE_DEPTH];
   ptr_type    rx_in, rx_out, tx_in, tx_out;
   logic       tx_busy;

   // Predicted results, oldest first
   rsp_type    due_results [$];

   initial begin
      error_count = 0;
      results_due = 0;
   end

   function automatic ptr_type wrap_inc(input ptr_type p);
      ptr_type n;
      if (int'(p) == QUEUE_DEPTH - 1) begin
         n = '0;
      end else begin
         n = p + ptr_type'(1);
      end
      return n;
   endfunction

   // Advance the shadow state by one event and return the result it causes
   function automatic rsp_type apply_event(input req_type t);
      rsp_type r;
      r = '0;
      r.accepted = 1'b1;
      case (func_type'(t.func))
         FUNC_RECV: begin
            if (wrap_inc(rx_in) == rx_out) begin
               r.accepted = 1'b0;
            end else begin
               rx_bytes[rx_in] = t.data_byte;
               rx_in = wrap_inc(rx_in);
            end
         end
         FUNC_TXDONE: begin
            if (tx_in != tx_out) begin
               r.send_valid = 1'b1;
               r.send_byte  = tx_bytes[tx_out];
               tx_out = wrap_inc(tx_out);
            end else begin
               tx_busy = 1'b0;
            end
         end
         FUNC_WRITE: begin
            if (!tx_busy) begin
               tx_busy      = 1'b1;
               r.send_valid = 1'b1;
               r.send_byte  = t.data_byte;
            end else if (wrap_inc(tx_in) == tx_out) begin
               r.accepted = 1'b0;
            end else begin
               tx_bytes[tx_in] = t.data_byte;
               tx_in = wrap_inc(tx_in);
            end
         end
         default: begin
            if (rx_in != rx_out) begin
               r.read_valid = 1'b1;
               r.read_byte  = rx_bytes[rx_out];
               rx_out = wrap_inc(rx_out);
            end
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rx_in   = '0;
         rx_out  = '0;
         tx_in   = '0;
         tx_out  = '0;
         tx_busy = 1'b0;
         due_results.delete();
      end else begin
         // compare a delivered result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result with nothing pending: %h", rsp_data);
               error_count++;
            end else begin
               want = due_results.pop_front();
               check_field("send_valid", want.send_valid, rsp_data.send_valid);
               check_field("send_byte", want.send_byte, rsp_data.send_byte);
               check_field("read_valid", want.read_valid, rsp_data.read_valid);
               check_field("read_byte", want.read_byte, rsp_data.read_byte);
               check_field("accepted", want.accepted, rsp_data.accepted);
            end
         end
         // predict for an accepted transaction
         if (req_valid && !req_stall) begin
            due_results.push_back(apply_event(req_data));
         end
      end
      results_due <= due_results.size();
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

   import buq_pkg::*;

   typedef enum int {
      MIX_EVENTS,
      FILL_RX,
      DRAIN_RX,
      FILL_TX,
      DRAIN_TX
   } traffic_kind;

   localparam int RANDOM_EVENTS = 800;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      error_count;
   int      results_due;
   int      burst_left = 0;
   int      stall_pct  = 0;
   int      stall_run  = 0;

   always #4 clock = ~clock;

   buffered_uart_byte_queues DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   buq_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .results_due (results_due)
   );

   // Stall the result side, switching between calm and busy stretches
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_run <= $urandom_range(200, 16);
         case ($urandom_range(3))
            0: begin
               stall_pct <= 0;
            end
            1: begin
               stall_pct <= 25;
            end
            2: begin
               stall_pct <= 50;
            end
            default: begin
               stall_pct <= 90;
            end
         endcase
      end else begin
         stall_run <= stall_run - 1;
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Offer one transaction, hold it until taken, then maybe pause the burst
   task automatic issue(input func_type f, input logic [7:0] d);
      req_type t;
      int      gap;
      t.func      = f;
      t.data_byte = d;
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(31, 1);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Bias the event mix toward the current traffic kind
   function automatic func_type pick_func(input traffic_kind k);
      func_type main_f;
      func_type f;
      case (k)
         FILL_RX: begin
            main_f = FUNC_RECV;
         end
         DRAIN_RX: begin
            main_f = FUNC_READ;
         end
         FILL_TX: begin
            main_f = FUNC_WRITE;
         end
         DRAIN_TX: begin
            main_f = FUNC_TXDONE;
         end
         default: begin
            main_f = func_type'($urandom_range(3));
         end
      endcase
      if ($urandom_range(99) < 90) begin
         f = main_f;
      end else begin
         f = func_type'($urandom_range(3));
      end
      return f;
   endfunction

   initial begin
      int          issued;
      int          run_len;
      traffic_kind kind;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty read, idle transmit complete, queued writes, receive path
      issue(FUNC_READ, 8'hFF);
      issue(FUNC_TXDONE, 8'h00);
      issue(FUNC_WRITE, 8'h00);
      issue(FUNC_WRITE, 8'hFF);
      issue(FUNC_WRITE, 8'hA5);
      issue(FUNC_TXDONE, 8'h3C);
      issue(FUNC_TXDONE, 8'h00);
      issue(FUNC_TXDONE, 8'h00);
      issue(FUNC_TXDONE, 8'hFF);
      issue(FUNC_WRITE, 8'h5A);
      issue(FUNC_RECV, 8'h00);
      issue(FUNC_RECV, 8'hFF);
      issue(FUNC_RECV, 8'h80);
      issue(FUNC_RECV, 8'h7F);
      issue(FUNC_READ, 8'h00);
      issue(FUNC_READ, 8'h55);
      issue(FUNC_READ, 8'hAA);
      issue(FUNC_READ, 8'h01);
      issue(FUNC_READ, 8'hFE);
      issue(FUNC_TXDONE, 8'h00);
      issue(FUNC_TXDONE, 8'h00);

      // random: phases long enough to fill and drain each ring past its wrap
      issued = 0;
      while (issued < RANDOM_EVENTS) begin
         kind    = traffic_kind'($urandom_range(4));
         run_len = $urandom_range(160, 80);
         repeat (run_len) begin
            issue(pick_func(kind), 8'($urandom_range(255)));
            issued++;
         end
      end
      req_valid <= 1'b0;

      // drain outstanding results, then watch for strays
      do @(posedge clock); while (results_due != 0);
      repeat (10) @(posedge clock);
      if (error_count == 0 && results_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* files.f */
design/buq_pkg.sv
design/buq_ram.sv
design/buq_ctrl.sv
design/buffered_uart_byte_queues.sv
verif/buq_checker.sv
verif/tb.sv
